// ----- rtl/second_order_iir_section_unit_macros.svh -----
// Assertion macros for the second-order IIR section unit.
`ifndef SECOND_ORDER_IIR_SECTION_UNIT_MACROS_SVH
`define SECOND_ORDER_IIR_SECTION_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IIR2_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define IIR2_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/iir2_pkg.sv -----
// Shared types and constants of the second-order IIR section unit.
package iir2_pkg;

    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_LSB = 2;

    typedef enum logic [1:0] {
        REG_FB_ONE   = 2'd0,
        REG_FB_TWO   = 2'd1,
        REG_IN_NOW   = 2'd2,
        REG_IN_PREV  = 2'd3
    } reg_index_t;

endpackage

// ----- rtl/second_order_iir_section_unit.sv -----
// Second-order IIR section: y = a1*y1 + a2*y2 + b0*x + b1*x1, rounded and saturated.
// A word accepted into the input register is computed combinationally and is written to the
// result register when that register is empty or being read. One word per cycle while result_ready
// stays high, set by the four parallel multipliers and adder between input and result registers.
// Reset clears the history, the pipeline valid bits and sets the coefficients
// to a1 = a2 = b1 = 0 and b0 = 1.0; any coefficient write clears the history.
`include "second_order_iir_section_unit_macros.svh"

module second_order_iir_section_unit
    import iir2_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 18
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [APB_ADDR_W-1:0]           paddr,
    input  logic [APB_DATA_W-1:0]           pwdata,
    output logic [APB_DATA_W-1:0]           prdata,
    output logic                            pready,

    input  logic                            sample_valid,
    output logic                            sample_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]  sample,

    output logic                            result_valid,
    input  logic                            result_ready,
    output logic signed [SAMPLE_WIDTH-1:0]  filtered,
    output logic                            clipped
);

    localparam int FRAC_SHIFT = COEF_WIDTH - 2;
    localparam int PROD_W     = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W      = PROD_W + 3;
    localparam int SH_W       = ACC_W - FRAC_SHIFT;

    localparam logic signed [COEF_WIDTH-1:0] COEF_ONE =
        COEF_WIDTH'(1) << FRAC_SHIFT;
    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        ACC_W'(1) << (FRAC_SHIFT - 1);
    localparam logic signed [SH_W-1:0] SAT_MAX =
        {{(SH_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [SH_W-1:0] SAT_MIN = ~SAT_MAX;

    logic signed [COEF_WIDTH-1:0]   coef_a1_reg;
    logic signed [COEF_WIDTH-1:0]   coef_a2_reg;
    logic signed [COEF_WIDTH-1:0]   coef_b0_reg;
    logic signed [COEF_WIDTH-1:0]   coef_b1_reg;

    logic signed [SAMPLE_WIDTH-1:0] last_output_reg;
    logic signed [SAMPLE_WIDTH-1:0] older_output_reg;
    logic signed [SAMPLE_WIDTH-1:0] last_input_reg;

    logic                           in_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] in_sample_reg;

    logic                           result_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] filtered_reg;
    logic                           clipped_reg;

    logic                           cfg_write;
    reg_index_t                     cfg_index;
    logic                           advance;

    logic signed [PROD_W-1:0]       prod_a1;
    logic signed [PROD_W-1:0]       prod_a2;
    logic signed [PROD_W-1:0]       prod_b0;
    logic signed [PROD_W-1:0]       prod_b1;
    logic signed [ACC_W-1:0]        acc_sum;
    logic signed [ACC_W-1:0]        acc_shifted;
    logic signed [SH_W-1:0]         rounded;
    logic signed [SAMPLE_WIDTH-1:0] filtered_next;
    logic                           clipped_next;

    logic                           clip_shown;
    logic                           clip_at_rail;
    logic                           history_clear;
    logic                           history_step;
    logic                           history_match;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[REG_IDX_LSB +: 2]);

    always_comb
    begin
        case (cfg_index)
            REG_FB_ONE:  prdata = APB_DATA_W'(coef_a1_reg);
            REG_FB_TWO:  prdata = APB_DATA_W'(coef_a2_reg);
            REG_IN_NOW:  prdata = APB_DATA_W'(coef_b0_reg);
            REG_IN_PREV: prdata = APB_DATA_W'(coef_b1_reg);
            default:     prdata = '0;
        endcase
    end

    assign advance      = in_valid_reg && (!result_valid_reg || result_ready);
    assign sample_ready = !in_valid_reg || advance;

    // The history registers are updated as each word advances, so each word sees the
    // outputs of the word just before it, unless a coefficient write has cleared them.
    always_comb
    begin
        prod_a1     = coef_a1_reg * last_output_reg;
        prod_a2     = coef_a2_reg * older_output_reg;
        prod_b0     = coef_b0_reg * in_sample_reg;
        prod_b1     = coef_b1_reg * last_input_reg;
        acc_sum     = ACC_W'(prod_a1) + ACC_W'(prod_a2) + ACC_W'(prod_b0)
                    + ACC_W'(prod_b1) + ROUND_HALF;
        acc_shifted = acc_sum >>> FRAC_SHIFT;
        rounded     = acc_shifted[SH_W-1:0];
        if (rounded > SAT_MAX)
        begin
            filtered_next = SAT_MAX[SAMPLE_WIDTH-1:0];
            clipped_next  = 1'b1;
        end
        else if (rounded < SAT_MIN)
        begin
            filtered_next = SAT_MIN[SAMPLE_WIDTH-1:0];
            clipped_next  = 1'b1;
        end
        else
        begin
            filtered_next = rounded[SAMPLE_WIDTH-1:0];
            clipped_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a1_reg      <= '0;
            coef_a2_reg      <= '0;
            coef_b0_reg      <= COEF_ONE;
            coef_b1_reg      <= '0;
            last_output_reg  <= '0;
            older_output_reg <= '0;
            last_input_reg   <= '0;
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FB_ONE:  coef_a1_reg <= pwdata[COEF_WIDTH-1:0];
                    REG_FB_TWO:  coef_a2_reg <= pwdata[COEF_WIDTH-1:0];
                    REG_IN_NOW:  coef_b0_reg <= pwdata[COEF_WIDTH-1:0];
                    REG_IN_PREV: coef_b1_reg <= pwdata[COEF_WIDTH-1:0];
                    default:     coef_a1_reg <= coef_a1_reg;
                endcase
                last_output_reg  <= '0;
                older_output_reg <= '0;
                last_input_reg   <= '0;
            end
            else if (advance)
            begin
                older_output_reg <= last_output_reg;
                last_output_reg  <= filtered_next;
                last_input_reg   <= in_sample_reg;
            end

            if (sample_ready)
            begin
                in_valid_reg <= sample_valid;
            end

            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ready && sample_valid)
        begin
            in_sample_reg <= sample;
        end
        if (advance)
        begin
            filtered_reg <= filtered_next;
            clipped_reg  <= clipped_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign filtered     = filtered_reg;
    assign clipped      = clipped_reg;

    assign clip_shown    = result_valid_reg && clipped_reg;
    assign clip_at_rail  = (filtered_reg == SAT_MAX[SAMPLE_WIDTH-1:0])
                        || (filtered_reg == SAT_MIN[SAMPLE_WIDTH-1:0]);
    assign history_clear = (last_output_reg == '0) && (older_output_reg == '0)
                        && (last_input_reg == '0);
    assign history_step  = advance && !cfg_write;
    assign history_match = result_valid_reg && (last_output_reg == filtered_reg);

    `IIR2_ASSERT_SAME(a_clip_at_rail, clip_shown, clip_at_rail, "Clipped word is not at a rail.")
    `IIR2_ASSERT_NEXT(a_cfg_clears, cfg_write, history_clear, "History not cleared by a write.")
    `IIR2_ASSERT_NEXT(a_history_tracks, history_step, history_match, "Stored output mismatch.")

endmodule
